// File: sv/tbb_pkg.sv
// Package for the transformed box bounds block: command codes, defaults, ALU op codes and control.
// No dependencies.
package tbb_pkg;
	localparam int COORD_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int CORNER_COUNT      = 8;
	localparam int FIELD_WIDTH       = 32;

	localparam logic [2:0] CMD_BOX_MIN  = 3'd0;
	localparam logic [2:0] CMD_BOX_MAX  = 3'd1;
	localparam logic [2:0] CMD_POSITION = 3'd2;
	localparam logic [2:0] CMD_SCALE    = 3'd3;
	localparam logic [2:0] CMD_ROTATION = 3'd4;
	localparam logic [2:0] CMD_INCLUDE  = 3'd5;
	localparam logic [2:0] CMD_CLEAR    = 3'd6;
	localparam logic [2:0] CMD_UNUSED   = 3'd7;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_SUB = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic       start;
	} alu_ctl_t;
endpackage

// File: sv/tbb_alu.sv
// Shared saturating fixed-point unit: multiply with rounding, add, subtract.
// Depends on tbb_pkg. Result registered for every operation; one operation per cycle.
module tbb_alu #(
	parameter int CW = tbb_pkg::COORD_WIDTH_DEF,
	parameter int FB = tbb_pkg::FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbb_pkg::alu_ctl_t    ctl,
	input  logic signed [CW-1:0] a,
	input  logic signed [CW-1:0] b,
	output logic signed [CW-1:0] y,
	output logic                 sat
);
	import tbb_pkg::*;
	localparam int PW = 2 * CW + 1;
	localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

	logic [CW:0] ma, mb;
	logic [PW-1:0] prod, rnd;
	logic [PW-1:0] mag;
	logic neg;
	logic signed [CW:0] sum;
	logic signed [CW-1:0] y_d;
	logic sat_d;

	always_comb begin
		ma = a[CW-1] ? -{a[CW-1], a} : {a[CW-1], a};
		mb = b[CW-1] ? -{b[CW-1], b} : {b[CW-1], b};
		neg = a[CW-1] ^ b[CW-1];
		prod = PW'(ma) * PW'(mb);
		rnd = prod + (PW'(1) << (FB - 1));
		mag = rnd >> FB;
		sum = '0;
		y_d = '0;
		sat_d = 1'b0;
		unique case (ctl.op)
			OP_MUL: begin
				if (!neg && mag > PW'(VMAX)) begin
					y_d = VMAX; sat_d = 1'b1;
				end else if (neg && mag > PW'(VMAX) + PW'(1)) begin
					y_d = VMIN; sat_d = 1'b1;
				end else begin
					y_d = neg ? -CW'(mag) : CW'(mag);
				end
			end
			OP_ADD, OP_SUB: begin
				sum = (ctl.op == OP_ADD) ? ({a[CW-1], a} + {b[CW-1], b})
					: ({a[CW-1], a} - {b[CW-1], b});
				if (sum[CW] != sum[CW-1]) begin
					y_d = sum[CW] ? VMIN : VMAX; sat_d = 1'b1;
				end else begin
					y_d = sum[CW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat <= 1'b0;
			y   <= '0;
		end else begin
			sat <= ctl.start & sat_d;
			y   <= y_d;
		end
	end
endmodule

// File: sv/transformed_box_bounds.sv
// Top level of the transformed box bounds accumulator.
// Depends on tbb_pkg and tbb_alu.
// Load, point and clear commands present their result in the cycle after acceptance, and
// the next transaction is taken in the cycle after the result leaves. An include of the box
// runs all arithmetic through one shared saturating multiply/add unit: 36 operations per
// corner, each issued and written back before the next is issued, for the eight corners in
// turn; the result appears once the last corner has been folded into the bounds. One result
// per accepted transaction.
module transformed_box_bounds #(
	parameter int COORD_WIDTH   = tbb_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = tbb_pkg::FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cmd[2:0], value_x[34:3], value_y[66:35], value_z[98:67], value_w[130:99], zero fill
	input  logic [135:0] s_tdata,
	// point_only
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z, is_empty[192], overflowed[193], zero fill
	output logic [199:0] m_tdata
);
	import tbb_pkg::*;
	localparam int CW = COORD_WIDTH;
	localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE  = (FRACTION_BITS >= CW - 1) ? VMAX
		: CW'(64'd1 << FRACTION_BITS);
	localparam int NSTEP = 42;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	// register file: 0-2 s,3-5 u,6-8 t,9-11 p0..p2 temps,12-14 w
	logic signed [CW-1:0] lmin_q [3], lmax_q [3], pos_q [3], scl_q [3], rot_q [4];
	logic signed [CW-1:0] bmin_q [3], bmax_q [3];
	logic signed [CW-1:0] r_q [16];
	logic empty_q, ovf_q;
	logic [1:0] state_q;
	logic [2:0] corner_q;
	logic [5:0] step_q;
	logic pend_q;
	logic [3:0] dst_q;

	logic signed [FIELD_WIDTH-1:0] va [4];
	logic signed [CW-1:0] vf [4];
	logic [3:0] vsat;
	logic [2:0] cmd;

	always_comb begin
		cmd = s_tdata[2:0];
		for (int i = 0; i < 4; i++) begin
			va[i] = $signed(s_tdata[3+32*i +: 32]);
			if (CW >= FIELD_WIDTH) begin
				vf[i] = CW'(va[i]);
				vsat[i] = 1'b0;
			end else if (va[i] > $signed(64'(VMAX))) begin
				vf[i] = VMAX; vsat[i] = 1'b1;
			end else if (va[i] < $signed(64'(VMIN))) begin
				vf[i] = VMIN; vsat[i] = 1'b1;
			end else begin
				vf[i] = CW'(va[i]); vsat[i] = 1'b0;
			end
		end
	end

	// microprogram: operand selectors; codes <16 register, 16+ sources
	typedef struct packed {
		logic [1:0] op;
		logic [4:0] a;
		logic [4:0] b;
		logic [3:0] d;
	} uop_t;
	// sources: 16+i local corner i, 19+i scale i, 22+i rot i, 26+i pos i
	function automatic uop_t ucode(input logic [5:0] k);
		uop_t u;
		u = '{OP_MUL, 5'd0, 5'd0, 4'd0};
		case (k)
			6'd0:  u = '{OP_MUL, 5'd16, 5'd19, 4'd0};
			6'd1:  u = '{OP_MUL, 5'd17, 5'd20, 4'd1};
			6'd2:  u = '{OP_MUL, 5'd18, 5'd21, 4'd2};
			6'd3:  u = '{OP_MUL, 5'd23, 5'd2, 4'd9};
			6'd4:  u = '{OP_MUL, 5'd24, 5'd1, 4'd10};
			6'd5:  u = '{OP_SUB, 5'd9, 5'd10, 4'd3};
			6'd6:  u = '{OP_MUL, 5'd24, 5'd0, 4'd9};
			6'd7:  u = '{OP_MUL, 5'd22, 5'd2, 4'd10};
			6'd8:  u = '{OP_SUB, 5'd9, 5'd10, 4'd4};
			6'd9:  u = '{OP_MUL, 5'd22, 5'd1, 4'd9};
			6'd10: u = '{OP_MUL, 5'd23, 5'd0, 4'd10};
			6'd11: u = '{OP_SUB, 5'd9, 5'd10, 4'd5};
			6'd12: u = '{OP_MUL, 5'd23, 5'd5, 4'd9};
			6'd13: u = '{OP_MUL, 5'd24, 5'd4, 4'd10};
			6'd14: u = '{OP_SUB, 5'd9, 5'd10, 4'd6};
			6'd15: u = '{OP_MUL, 5'd24, 5'd3, 4'd9};
			6'd16: u = '{OP_MUL, 5'd22, 5'd5, 4'd10};
			6'd17: u = '{OP_SUB, 5'd9, 5'd10, 4'd7};
			6'd18: u = '{OP_MUL, 5'd22, 5'd4, 4'd9};
			6'd19: u = '{OP_MUL, 5'd23, 5'd3, 4'd10};
			6'd20: u = '{OP_SUB, 5'd9, 5'd10, 4'd8};
			default: begin
				// per axis i: 7 steps starting at 21+7i, five ops then two idle steps
				logic [5:0] j;
				logic [1:0] i;
				j = k - 6'd21;
				i = (j < 6'd7) ? 2'd0 : (j < 6'd14) ? 2'd1 : 2'd2;
				j = j - 6'(7 * i);
				case (j)
					6'd0: u = '{OP_MUL, 5'd3 + 5'(i), 5'd25, 4'd11};
					6'd1: u = '{OP_ADD, 5'd11, 5'd6 + 5'(i), 4'd11};
					6'd2: u = '{OP_ADD, 5'd11, 5'd11, 4'd11};
					6'd3: u = '{OP_ADD, 5'd0 + 5'(i), 5'd11, 4'd11};
					6'd4: u = '{OP_ADD, 5'd26 + 5'(i), 5'd11, 4'd12 + 4'(i)};
					default: u = '{OP_ADD, 5'd0, 5'd0, 4'd15};
				endcase
			end
		endcase
		return u;
	endfunction

	uop_t uop;
	logic signed [CW-1:0] opa, opb, alu_y;
	logic alu_sat, issue;
	alu_ctl_t actl;

	function automatic logic signed [CW-1:0] src(input logic [4:0] s, input logic [2:0] c,
		input logic signed [CW-1:0] rf [16], input logic signed [CW-1:0] l0 [3],
		input logic signed [CW-1:0] l1 [3], input logic signed [CW-1:0] sc [3],
		input logic signed [CW-1:0] ro [4], input logic signed [CW-1:0] po [3]);
		logic signed [CW-1:0] v;
		v = '0;
		if (s < 5'd16) v = rf[s[3:0]];
		else if (s < 5'd19) v = c[2'(s - 5'd16)] ? l1[2'(s - 5'd16)] : l0[2'(s - 5'd16)];
		else if (s < 5'd22) v = sc[2'(s - 5'd19)];
		else if (s < 5'd26) v = ro[2'(s - 5'd22)];
		else if (s < 5'd29) v = po[2'(s - 5'd26)];
		return v;
	endfunction

	always_comb begin
		uop = ucode(step_q);
		opa = src(uop.a, corner_q, r_q, lmin_q, lmax_q, scl_q, rot_q, pos_q);
		opb = src(uop.b, corner_q, r_q, lmin_q, lmax_q, scl_q, rot_q, pos_q);
		issue = (state_q == ST_RUN) && (uop.d != 4'd15) && !pend_q;
		actl.op = uop.op;
		actl.start = issue;
	end

	tbb_alu #(.CW(CW), .FB(FRACTION_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(actl), .a(opa), .b(opb), .y(alu_y), .sat(alu_sat)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);

	function automatic logic [31:0] o32(input logic signed [CW-1:0] v);
		if (CW <= FIELD_WIDTH) return 32'($signed(v));
		if (v > $signed(CW'(32'h7fffffff))) return 32'h7fffffff;
		if (v < -$signed(CW'(33'h080000000))) return 32'h80000000;
		return v[31:0];
	endfunction

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 3; i++) begin
			m_tdata[32*i +: 32] = o32(bmin_q[i]);
			m_tdata[96+32*i +: 32] = o32(bmax_q[i]);
		end
		m_tdata[192] = empty_q;
		m_tdata[193] = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			corner_q <= '0;
			step_q <= '0;
			pend_q <= 1'b0;
			dst_q <= '0;
			empty_q <= 1'b1;
			ovf_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lmin_q[i] <= '0; lmax_q[i] <= '0; pos_q[i] <= '0; scl_q[i] <= ONE;
				rot_q[i] <= '0; bmin_q[i] <= VMAX; bmax_q[i] <= VMIN;
			end
			rot_q[3] <= ONE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					state_q <= ST_OUT;
					case (cmd)
						CMD_BOX_MIN: begin
							for (int i = 0; i < 3; i++) lmin_q[i] <= vf[i];
							ovf_q <= ovf_q | (|vsat[2:0]);
						end
						CMD_BOX_MAX: begin
							for (int i = 0; i < 3; i++) lmax_q[i] <= vf[i];
							ovf_q <= ovf_q | (|vsat[2:0]);
						end
						CMD_POSITION: begin
							for (int i = 0; i < 3; i++) pos_q[i] <= vf[i];
							ovf_q <= ovf_q | (|vsat[2:0]);
						end
						CMD_SCALE: begin
							for (int i = 0; i < 3; i++) scl_q[i] <= vf[i];
							ovf_q <= ovf_q | (|vsat[2:0]);
						end
						CMD_ROTATION: begin
							for (int i = 0; i < 4; i++) rot_q[i] <= vf[i];
							ovf_q <= ovf_q | (|vsat);
						end
						CMD_INCLUDE: begin
							if (s_tuser) begin
								for (int i = 0; i < 3; i++) begin
									if (vf[i] < bmin_q[i]) bmin_q[i] <= vf[i];
									if (vf[i] > bmax_q[i]) bmax_q[i] <= vf[i];
								end
								empty_q <= 1'b0;
								ovf_q <= ovf_q | (|vsat[2:0]);
							end else begin
								state_q <= ST_RUN;
								corner_q <= '0;
								step_q <= '0;
								pend_q <= 1'b0;
							end
						end
						CMD_CLEAR: begin
							for (int i = 0; i < 3; i++) begin
								bmin_q[i] <= VMAX; bmax_q[i] <= VMIN;
							end
							empty_q <= 1'b1;
							ovf_q <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_RUN: begin
					if (pend_q) begin
						r_q[dst_q] <= alu_y;
						ovf_q <= ovf_q | alu_sat;
						pend_q <= 1'b0;
						step_q <= step_q + 6'd1;
					end else if (issue) begin
						pend_q <= 1'b1;
						dst_q <= uop.d;
					end else if (step_q >= 6'(NSTEP)) begin
						for (int i = 0; i < 3; i++) begin
							if (r_q[12+i] < bmin_q[i]) bmin_q[i] <= r_q[12+i];
							if (r_q[12+i] > bmax_q[i]) bmax_q[i] <= r_q[12+i];
						end
						empty_q <= 1'b0;
						step_q <= '0;
						corner_q <= corner_q + 3'd1;
						if (corner_q == 3'(CORNER_COUNT - 1)) state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && cmd == CMD_CLEAR) |=> !ovf_q) else $error("clear kept overflow");
	a_inc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && $past(state_q) == ST_RUN && corner_q != 3'd0) |-> !empty_q)
		else $error("box empty during include");
endmodule

// File: tb/sv/tb_top.sv
// Testbench for transformed_box_bounds: drives command transactions, predicts the running
// world bounds with a fixed-point model of its own and checks every whole result against it.
// Depends on tbb_pkg and the transformed_box_bounds RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tbb_pkg::*;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint ONE = 64'sd65536;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        overflowed, is_empty;
		logic [31:0] max_z, max_y, max_x, min_z, min_y, min_x;
	} bounds_t;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, s_tuser;
	logic [135:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [199:0] m_tdata;

	transformed_box_bounds dut (.*);

	longint  box_lo[3], box_hi[3], pos[3], scl[3], rot[4], bmin[3], bmax[3];
	bit      empty_st, ovf_st;
	bounds_t bounds_q[$];
	int      mismatches, checked, idle_cycles, n_boxes, n_points;
	bit      stall_en;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat(longint v);
		if (v > VMAX) begin
			ovf_st = 1;
			return VMAX;
		end
		if (v < VMIN) begin
			ovf_st = 1;
			return VMIN;
		end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] m;
		bit neg;
		neg = (a < 0) != (b < 0);
		m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		m = (m + 128'd32768) >> 16;
		if (m > (neg ? 128'd2147483648 : 128'd2147483647)) begin
			ovf_st = 1;
			return neg ? VMIN : VMAX;
		end
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic void cross3(longint a[4], longint b[3], output longint r[3]);
		r[0] = sat(qmul(a[1], b[2]) - qmul(a[2], b[1]));
		r[1] = sat(qmul(a[2], b[0]) - qmul(a[0], b[2]));
		r[2] = sat(qmul(a[0], b[1]) - qmul(a[1], b[0]));
	endfunction

	function automatic void grow_bounds(longint p[3]);
		for (int i = 0; i < 3; i++) begin
			if (p[i] < bmin[i]) bmin[i] = p[i];
			if (p[i] > bmax[i]) bmax[i] = p[i];
		end
		empty_st = 0;
	endfunction

	function automatic void clear_bounds();
		for (int i = 0; i < 3; i++) begin
			bmin[i] = VMAX;
			bmax[i] = VMIN;
		end
		empty_st = 1;
		ovf_st = 0;
	endfunction

	function automatic void include_corners();
		longint s[3], u[3], t[3], w[3], k;
		for (int c = 0; c < CORNER_COUNT; c++) begin
			for (int i = 0; i < 3; i++)
				s[i] = qmul(((c >> i) & 1) ? box_hi[i] : box_lo[i], scl[i]);
			cross3(rot, s, u);
			cross3(rot, u, t);
			for (int i = 0; i < 3; i++) begin
				k = sat(qmul(u[i], rot[3]) + t[i]);
				k = sat(k + k);
				w[i] = sat(pos[i] + sat(s[i] + k));
			end
			grow_bounds(w);
		end
	endfunction

	function automatic void predict_bounds(logic [2:0] cmd, longint v[4], bit pt);
		bounds_t b;
		case (cmd)
			CMD_BOX_MIN: for (int i = 0; i < 3; i++) box_lo[i] = v[i];
			CMD_BOX_MAX: for (int i = 0; i < 3; i++) box_hi[i] = v[i];
			CMD_POSITION: for (int i = 0; i < 3; i++) pos[i] = v[i];
			CMD_SCALE: for (int i = 0; i < 3; i++) scl[i] = v[i];
			CMD_ROTATION: for (int i = 0; i < 4; i++) rot[i] = v[i];
			CMD_INCLUDE: begin
				if (pt) begin
					grow_bounds('{v[0], v[1], v[2]});
					n_points++;
				end else begin
					include_corners();
					n_boxes++;
				end
			end
			CMD_CLEAR: clear_bounds();
			default: ;
		endcase
		b.min_x = 32'(bmin[0]); b.min_y = 32'(bmin[1]); b.min_z = 32'(bmin[2]);
		b.max_x = 32'(bmax[0]); b.max_y = 32'(bmax[1]); b.max_z = 32'(bmax[2]);
		b.is_empty = empty_st;
		b.overflowed = ovf_st;
		bounds_q.insert(bounds_q.size(), b);
	endfunction

	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return;
		repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk);
	endtask

	task automatic send_cmd(logic [2:0] cmd, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] w, bit pt);
		longint v[4];
		if (stall_en) idle_gap();
		s_tdata <= {5'd0, w, z, y, x, cmd};
		s_tuser <= pt;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		v = '{longint'(signed'(x)), longint'(signed'(y)), longint'(signed'(z)),
			longint'(signed'(w))};
		predict_bounds(cmd, v, pt);
		@(negedge clk);
		s_tvalid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_quat();
		return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
	endfunction

	// check each result against the oldest prediction
	always @(posedge clk) begin
		bounds_t got, exp_b;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[193:0];
			if (bounds_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				exp_b = bounds_q.pop_front();
				checked++;
				if (got !== exp_b) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", exp_b, got);
				end
			end
		end
	end

	always @(negedge clk) m_tready <= stall_en ? ($urandom_range(0, 99) < 70) : 1'b1;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout");
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_directed();
		send_cmd(CMD_INCLUDE, 0, 0, 0, 0, 1'b0);
		send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
		send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 1, 2, 3, 1'b1);
		send_cmd(CMD_INCLUDE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_5555,
			1'b1);
		send_cmd(CMD_BOX_MIN, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000, 0, 1'b0);
		send_cmd(CMD_BOX_MAX, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_FFFF,
			1'b1);
		send_cmd(CMD_POSITION, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 0, 1'b0);
		send_cmd(CMD_SCALE, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 0, 1'b0);
		send_cmd(CMD_ROTATION, 0, 0, 32'h0000_B505, 32'h0000_B505, 1'b0);
		send_cmd(CMD_INCLUDE, 0, 0, 0, 0, 1'b0);
		send_cmd(CMD_ROTATION, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA, 32'h8000_0000,
			1'b0);
		send_cmd(CMD_INCLUDE, 0, 0, 0, 0, 1'b0);
		send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_cmd(CMD_ROTATION, 0, 0, 0, 32'h0001_0000, 1'b0);
		send_cmd(CMD_BOX_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b0);
		send_cmd(CMD_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
		send_cmd(CMD_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b0);
		send_cmd(CMD_INCLUDE, 0, 0, 0, 0, 1'b0);
		send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
	endtask

	task automatic test_random();
		logic [2:0] cmd;
		for (int n = 0; n < 650; n++) begin
			stall_en = (n % 200) < 150;
			cmd = $urandom_range(0, 99) < 5 ? CMD_UNUSED :
				($urandom_range(0, 2) == 0 ? CMD_INCLUDE : 3'($urandom_range(0, 6)));
			if (cmd == CMD_ROTATION && $urandom_range(0, 3) != 0)
				send_cmd(cmd, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
					1'($urandom));
			else if (cmd == CMD_CLEAR && $urandom_range(0, 2) != 0)
				send_cmd(CMD_INCLUDE, rand_val(), rand_val(), rand_val(), $urandom, 1'b1);
			else
				send_cmd(cmd, rand_val(), rand_val(), rand_val(), $urandom,
					$urandom_range(0, 3) == 0 ? 1'b0 : 1'b1);
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		stall_en = 1;
		ovf_st = 0;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 0; box_hi[i] = 0; pos[i] = 0; scl[i] = ONE; rot[i] = 0;
		end
		rot[3] = ONE;
		clear_bounds();
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_random();
		while (bounds_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("covered %0d results: %0d box includes, %0d point includes", checked,
			n_boxes, n_points);
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule
